FILE: design/substring_position_finder_macros.svh
// Assertion macros shared by the substring position finder checkers.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef SUBSTRING_POSITION_FINDER_MACROS_SVH
`define SUBSTRING_POSITION_FINDER_MACROS_SVH

// Same-cycle implication
`define SPF_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) else $error(msg);

// Next-cycle implication
`define SPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) else $error(msg);

`endif

FILE: design/spf_pkg.sv
// Shared types and constants for the substring position finder.
// Used by spf_regs, spf_core and the top level; depends on nothing.
package spf_pkg;

  localparam logic [7:0]  ACCENT_BYTE = 8'hC3;
  localparam logic [15:0] CNT_MAX     = 16'hFFFF;
  localparam logic [3:0]  GAP_MAX     = 4'd8;

  // Register address bit that selects the length register
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned REG_SEL_BIT = 3;

  typedef struct packed {
    logic [63:0] pattern;
    logic [3:0]  length;
  } spf_cfg_t;

  typedef struct packed {
    logic        found;
    logic [15:0] start;
    logic [15:0] stop;
    logic [15:0] total;
  } spf_res_t;

endpackage

FILE: design/spf_regs.sv
// Configuration registers of the substring position finder (pattern, length).
// APB-style write and read; depends on spf_pkg.
module spf_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [spf_pkg::ADDR_W-1:0]  paddr,
  input  logic [63:0]                 pwdata,
  output logic [63:0]                 prdata,
  output spf_pkg::spf_cfg_t           cfg_o
);
  import spf_pkg::*;

  logic [63:0] pattern_r;
  logic [3:0]  length_r;
  logic        wr_en;

  assign wr_en = psel && penable && pwrite;

  // Write pattern at the low half of the map, length at the high half
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      length_r  <= '0;
    end else if (wr_en) begin
      if (paddr[REG_SEL_BIT]) begin
        length_r <= pwdata[3:0];
      end else begin
        pattern_r <= pwdata;
      end
    end
  end

  // Read back the addressed register
  assign prdata = paddr[REG_SEL_BIT] ? {60'd0, length_r} : pattern_r;

  assign cfg_o.pattern = pattern_r;
  assign cfg_o.length  = length_r;

endmodule

FILE: design/spf_core.sv
// Match engine: byte window, counters and the compare/update step for each byte.
// Depends on spf_pkg for the config and result structs.
module spf_core #(
  parameter int MAX_PATTERN = 8,
  parameter int POS_W       = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  logic              first_i,
  input  spf_pkg::spf_cfg_t cfg_i,
  output spf_pkg::spf_res_t res_o
);
  import spf_pkg::*;

  localparam logic [POS_W-1:0] POS_MAX = '1;
  localparam logic [POS_W-1:0] ACC_MAX = (POS_W > 16) ? POS_W'(CNT_MAX) : POS_MAX;
  localparam logic [3:0]       MAX_LEN = 4'(MAX_PATTERN);

  // Window, entry 0 newest
  logic [7:0]             win_r   [MAX_PATTERN];
  logic [7:0]             win_nxt [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] flag_r, flag_nxt, flag_sh;
  logic [POS_W-1:0]       pos_r, pos_nxt, pos_base;
  logic [POS_W-1:0]       acc_r, acc_nxt, acc_base, acc_inc;
  logic [3:0]             gap_r, gap_nxt, gap_base, gap_inc;
  logic [15:0]            cnt_r, cnt_nxt, cnt_base;

  logic [3:0]       len;
  logic             len_ok;
  logic             eq;
  logic             hit;
  logic [3:0]       pk;
  logic [3:0]       pop;
  logic [POS_W-1:0] pos_len;
  logic [POS_W-1:0] first_pos;
  logic [POS_W-1:0] start_v;
  logic [POS_W-1:0] stop_v;

  // Compute the next state and the result of one byte
  always_comb begin
    len = cfg_i.length;

    // Start of a new text clears the history
    pos_base = first_i ? '0 : pos_r;
    acc_base = first_i ? '0 : acc_r;
    gap_base = first_i ? '0 : gap_r;
    cnt_base = first_i ? '0 : cnt_r;

    // Shift the new byte in
    win_nxt[0] = byte_i;
    flag_sh[0] = (byte_i == ACCENT_BYTE);
    for (int k = 1; k < MAX_PATTERN; k++) begin
      win_nxt[k] = first_i ? 8'd0 : win_r[k-1];
      flag_sh[k] = first_i ? 1'b0 : flag_r[k-1];
    end

    // Saturating counters
    acc_inc = (flag_sh[0] && acc_base != ACC_MAX) ? acc_base + POS_W'(1) : acc_base;
    pos_nxt = (pos_base != POS_MAX) ? pos_base + POS_W'(1) : pos_base;
    gap_inc = (gap_base < GAP_MAX) ? gap_base + 4'd1 : gap_base;

    // Compare the window against the pattern, last pattern byte at entry 0
    pos_len = POS_W'(len);
    len_ok  = (len != 4'd0) && (len <= MAX_LEN) && (gap_inc >= len) && (pos_nxt >= pos_len);
    eq = 1'b1;
    pk = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (4'(i) < len) begin
        pk = len - 4'(i) - 4'd1;
        if (win_nxt[i] != cfg_i.pattern[8*pk[2:0] +: 8]) begin
          eq = 1'b0;
        end
      end
    end
    hit = len_ok && eq;

    // Drop counted accents inside the match after its first byte
    pop      = '0;
    flag_nxt = flag_sh;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (4'(i + 1) < len) begin
        pop = pop + 4'(flag_sh[i]);
        if (hit) begin
          flag_nxt[i] = 1'b0;
        end
      end
    end
    if (hit) begin
      acc_nxt = (acc_inc > POS_W'(pop)) ? acc_inc - POS_W'(pop) : '0;
    end else begin
      acc_nxt = acc_inc;
    end

    // Positions less accents, floored at zero
    first_pos = pos_nxt - pos_len + POS_W'(1);
    start_v   = (first_pos > acc_nxt) ? first_pos - acc_nxt : '0;
    stop_v    = (pos_nxt > acc_nxt) ? pos_nxt - acc_nxt : '0;

    gap_nxt = hit ? 4'd0 : gap_inc;
    cnt_nxt = (hit && cnt_base != CNT_MAX) ? cnt_base + 16'd1 : cnt_base;

    res_o.found = hit;
    res_o.start = hit ? 16'(start_v) : 16'd0;
    res_o.stop  = hit ? 16'(stop_v) : 16'd0;
    res_o.total = cnt_nxt;
  end

  // Advance the state on every processed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
        win_r[k] <= 8'd0;
      end
      flag_r <= '0;
      pos_r  <= '0;
      acc_r  <= '0;
      gap_r  <= GAP_MAX;
      cnt_r  <= '0;
    end else if (step_i) begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
        win_r[k] <= win_nxt[k];
      end
      flag_r <= flag_nxt;
      pos_r  <= pos_nxt;
      acc_r  <= acc_nxt;
      gap_r  <= gap_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

FILE: design/substring_position_finder.sv
// Substring position finder: scans a byte stream for leftmost, non-overlapping
// occurrences of a pattern of up to MAX_PATTERN bytes and emits one result word
// per text byte. A byte word enters an input register, the match step runs on it
// once the output register is free or draining, and its result lands in an output
// register. One byte is taken every cycle as long as the output side keeps taking
// results. The rate is set by the registered update of the byte window and the
// position and accent counters, which the next byte needs.
// Configuration (pattern at address 0, length at address 8) must be written while idle.
module substring_position_finder #(
  parameter int MAX_PATTERN   = 8,
  parameter int POSITION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Text byte input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tuser,   // [0] first_of_text
  // Match results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [15:0] match_start, [31:16] match_end, [47:32] match_total
  output logic        out_tuser,  // [0] match_found
  // Configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  import spf_pkg::*;

  spf_cfg_t   cfg;
  spf_res_t   res;
  spf_res_t   out_r;
  logic       out_v_r;
  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       in_first_r;
  logic       fire;

  assign cfg_pready = 1'b1;

  spf_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg_o   (cfg)
  );

  // Process the held byte when the output register is free or draining
  assign fire      = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || fire;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r  <= in_tdata;
      in_first_r <= in_tuser;
    end
  end

  spf_core #(
    .MAX_PATTERN (MAX_PATTERN),
    .POS_W       (POSITION_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_i  (fire),
    .byte_i  (in_byte_r),
    .first_i (in_first_r),
    .cfg_i   (cfg),
    .res_o   (res)
  );

  // Output register: hold while stalled, load on each processed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (fire) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_r.found;
  assign out_tdata  = {out_r.total, out_r.stop, out_r.start};

endmodule

FILE: design/spf_checker.sv
// Port-level checks for the substring position finder, bound to the top level.
// Depends on substring_position_finder_macros.svh.
`include "substring_position_finder_macros.svh"

module spf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        out_tuser
);

  // A stalled result word holds
  `SPF_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, (out_tvalid && $stable(out_tdata) && $stable(out_tuser)), "result word changed while stalled")

  // Positions read zero when nothing was found
  `SPF_ASSERT(a_no_match_zero, out_tvalid && !out_tuser, (out_tdata[31:0] == 32'd0), "positions set without a match")

  // A reported match is always counted
  `SPF_ASSERT(a_match_counted, out_tvalid && out_tuser, (out_tdata[47:32] != 16'd0), "match reported with zero total")

  // A byte taken while the output register is empty is followed by a valid result word
  `SPF_ASSERT(a_result_latency, in_tvalid && in_tready && !out_tvalid, ##2 out_tvalid, "no result after accepted byte")

endmodule

bind substring_position_finder spf_checker u_spf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

FILE: tb/testbench.sv
// Self-checking testbench for substring_position_finder: APB setup, byte stream
// in, one match word out per byte. Needs spf_pkg and the top level RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import spf_pkg::*;

  localparam logic [3:0] PATTERN_ADDR = 4'h0;
  localparam logic [3:0] LENGTH_ADDR  = 4'h8;
  localparam int unsigned WINDOW      = 8;
  localparam int unsigned POS_LIMIT   = 65535;
  localparam int RANDOM_ITEMS         = 1400;

  typedef enum logic [1:0] {ROW_BYTE, ROW_PATTERN, ROW_LENGTH} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [63:0] value;
    logic        first;
    logic        fixed;
    spf_res_t    want;
  } dir_row_t;

  localparam spf_res_t NO_MATCH = '0;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        out_tuser;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  substring_position_finder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  // Shadow of the block: pattern setup and scan state
  logic [63:0] shadow_pattern = '0;
  logic [3:0]  shadow_length = '0;
  logic [7:0]  window_bytes [WINDOW];
  bit   [7:0]  window_accent = '0;
  int unsigned text_pos = 0;
  int unsigned accent_total = 0;
  int unsigned gap_since_match = 8;
  int unsigned match_tally = 0;

  spf_res_t pending_matches [$];
  int       mismatch_count = 0;
  bit       idle_on = 1'b1;
  int       stall_left = 0;
  spf_res_t seen_res;
  spf_res_t due_res;

  // Directed words; rows with fixed set carry the expected result typed in
  dir_row_t dir_rows [34] = '{
    '{ROW_BYTE,    64'h00,   1'b0, 1'b1, NO_MATCH},
    '{ROW_BYTE,    64'hFF,   1'b0, 1'b1, NO_MATCH},
    '{ROW_PATTERN, 64'h6261, 1'b0, 1'b0, NO_MATCH},
    '{ROW_LENGTH,  64'd2,    1'b0, 1'b0, NO_MATCH},
    '{ROW_BYTE,    64'h61,   1'b1, 1'b1, NO_MATCH},
    '{ROW_BYTE,    64'h62,   1'b0, 1'b1, spf_res_t'{1'b1, 16'd1, 16'd2, 16'd1}},
    '{ROW_BYTE,    64'h62,   1'b0, 1'b1, spf_res_t'{1'b0, 16'd0, 16'd0, 16'd1}},
    '{ROW_BYTE,    64'hC3,   1'b1, 1'b1, NO_MATCH},
    '{ROW_BYTE,    64'h61,   1'b0, 1'b1, NO_MATCH},
    '{ROW_BYTE,    64'h62,   1'b0, 1'b1, spf_res_t'{1'b1, 16'd1, 16'd2, 16'd1}},
    // new text too short to hold the pattern
    '{ROW_BYTE,    64'h62,   1'b1, 1'b1, NO_MATCH},
    // overlapping occurrences: only every other one is taken
    '{ROW_PATTERN, 64'h6161, 1'b0, 1'b0, NO_MATCH},
    '{ROW_BYTE,    64'h61,   1'b1, 1'b0, NO_MATCH},
    '{ROW_BYTE,    64'h61,   1'b0, 1'b0, NO_MATCH},
    '{ROW_BYTE,    64'h61,   1'b0, 1'b0, NO_MATCH},
    '{ROW_BYTE,    64'h61,   1'b0, 1'b0, NO_MATCH},
    // accent byte inside a match is taken back off the count
    '{ROW_PATTERN, 64'hC361, 1'b0, 1'b0, NO_MATCH},
    '{ROW_BYTE,    64'h61,   1'b1, 1'b0, NO_MATCH},
    '{ROW_BYTE,    64'hC3,   1'b0, 1'b0, NO_MATCH},
    // lengths beyond the window never match
    '{ROW_LENGTH,  64'd9,    1'b0, 1'b0, NO_MATCH},
    '{ROW_PATTERN, 64'h0,    1'b0, 1'b0, NO_MATCH},
    '{ROW_BYTE,    64'h00,   1'b1, 1'b1, NO_MATCH},
    '{ROW_LENGTH,  64'd15,   1'b0, 1'b0, NO_MATCH},
    '{ROW_BYTE,    64'h00,   1'b0, 1'b1, NO_MATCH},
    // full-width pattern
    '{ROW_PATTERN, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, NO_MATCH},
    '{ROW_LENGTH,  64'd8,    1'b0, 1'b0, NO_MATCH},
    '{ROW_BYTE,    64'hFF,   1'b1, 1'b0, NO_MATCH},
    '{ROW_BYTE,    64'hFF,   1'b0, 1'b0, NO_MATCH},
    '{ROW_BYTE,    64'hFF,   1'b0, 1'b0, NO_MATCH},
    '{ROW_BYTE,    64'hFF,   1'b0, 1'b0, NO_MATCH},
    '{ROW_BYTE,    64'hFF,   1'b0, 1'b0, NO_MATCH},
    '{ROW_BYTE,    64'hFF,   1'b0, 1'b0, NO_MATCH},
    '{ROW_BYTE,    64'hFF,   1'b0, 1'b0, NO_MATCH},
    '{ROW_BYTE,    64'hFF,   1'b0, 1'b0, NO_MATCH}
  };

  // Advance the shadow scan by one text byte and return its match word
  function automatic spf_res_t scan_byte(input logic [7:0] text_byte, input logic first);
    spf_res_t    res;
    bit          same;
    int unsigned head;
    res = '0;
    if (first) begin
      foreach (window_bytes[k]) window_bytes[k] = '0;
      window_accent = '0;
      text_pos = 0;
      accent_total = 0;
      match_tally = 0;
      gap_since_match = 0;
    end
    for (int k = WINDOW - 1; k > 0; k--) window_bytes[k] = window_bytes[k - 1];
    window_accent = window_accent << 1;
    window_bytes[0] = text_byte;
    window_accent[0] = (text_byte == ACCENT_BYTE);
    if (text_byte == ACCENT_BYTE && accent_total < POS_LIMIT) accent_total++;
    if (text_pos < POS_LIMIT) text_pos++;
    if (gap_since_match < 8) gap_since_match++;
    if (shadow_length >= 1 && shadow_length <= WINDOW &&
        gap_since_match >= shadow_length && text_pos >= shadow_length) begin
      same = 1'b1;
      for (int i = 0; i < shadow_length; i++)
        if (window_bytes[i] != shadow_pattern[8 * (shadow_length - 1 - i) +: 8]) same = 1'b0;
      if (same) begin
        // drop accents that sit after the first byte of the match
        for (int i = 0; i + 1 < shadow_length; i++) begin
          if (window_accent[i]) begin
            if (accent_total > 0) accent_total--;
            window_accent[i] = 1'b0;
          end
        end
        head = text_pos - shadow_length + 1;
        res.found = 1'b1;
        res.start = (head > accent_total) ? 16'(head - accent_total) : 16'd0;
        res.stop  = (text_pos > accent_total) ? 16'(text_pos - accent_total) : 16'd0;
        gap_since_match = 0;
        if (match_tally < POS_LIMIT) match_tally++;
      end
    end
    res.total = 16'(match_tally);
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Bias toward a small alphabet so that patterns show up in the text
  function automatic logic [7:0] pick_text_byte();
    case ($urandom_range(0, 3))
      0: return 8'h61;
      1: return 8'h62;
      2: return ACCENT_BYTE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // APB write: setup cycle, access cycle, then release the bus
  task automatic cfg_write(input logic [3:0] addr, input logic [63:0] data);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr == PATTERN_ADDR) shadow_pattern = data;
    else shadow_length = data[3:0];
    @(negedge clk);
  endtask

  // Drop valid and hold until every expected word is back, plus the pipe depth
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_matches.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Offer one text byte, hold it until taken, then log its expected word
  task automatic feed_byte(input logic [7:0] text_byte, input logic first,
                           input logic fixed, input spf_res_t want);
    int       gap;
    spf_res_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= text_byte;
    in_tuser <= first;
    do @(posedge clk); while (!in_tready);
    predicted = scan_byte(text_byte, first);
    pending_matches.push_back(fixed ? want : predicted);
    @(negedge clk);
  endtask

  // Random setup, then texts built mostly from whole or damaged pattern copies
  task automatic random_phase(input int n_items, output int sent);
    logic [7:0]  seg [$];
    logic [63:0] pat;
    logic [3:0]  len;
    int          r;
    int          cut;
    int          span;
    bit          new_text;
    r = $urandom_range(0, 19);
    if (r == 0) len = 4'd0;
    else if (r == 1) len = 4'($urandom_range(9, 15));
    else if (r < 5) len = 4'd8;
    else len = 4'($urandom_range(1, 8));
    for (int k = 0; k < 8; k++) pat[8 * k +: 8] = pick_text_byte();
    cfg_write(PATTERN_ADDR, pat);
    cfg_write(LENGTH_ADDR, {$urandom, 28'($urandom), len});
    idle_on = ($urandom_range(0, 3) != 0);
    span = (len >= 1 && len <= WINDOW) ? len : 3;
    new_text = 1'b1;
    sent = 0;
    while (sent < n_items) begin
      seg.delete();
      r = $urandom_range(0, 9);
      if (r <= 3) begin
        for (int k = 0; k < span; k++) seg.push_back(pat[8 * k +: 8]);
      end else if (r <= 5) begin
        cut = $urandom_range(0, span - 1);
        for (int k = 0; k < span; k++)
          seg.push_back(k == cut ? pat[8 * k +: 8] ^ 8'(1 << $urandom_range(0, 7))
                                 : pat[8 * k +: 8]);
      end else if (r <= 7) begin
        seg.push_back(pick_text_byte());
      end else if (r == 8) begin
        seg.push_back(8'($urandom_range(0, 255)));
      end else begin
        new_text = 1'b1;
      end
      foreach (seg[k]) begin
        feed_byte(seg[k], new_text, 1'b0, NO_MATCH);
        new_text = 1'b0;
        sent++;
      end
      if ($urandom_range(0, 299) == 0) wait_drained();
    end
    wait_drained();
  endtask

  // Result side: random stalls on tready
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (pick_gap() > 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare each taken result word with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_res = {out_tuser, out_tdata[15:0], out_tdata[31:16], out_tdata[47:32]};
      if (pending_matches.size() == 0) begin
        mismatch_count++;
        $display("%0t: result word with none expected: found=%0d start=%0d end=%0d total=%0d",
                 $time, seen_res.found, seen_res.start, seen_res.stop, seen_res.total);
      end else begin
        due_res = pending_matches.pop_front();
        if (seen_res.found !== due_res.found || seen_res.start !== due_res.start ||
            seen_res.stop !== due_res.stop || seen_res.total !== due_res.total) begin
          mismatch_count++;
          $display("%0t: match word mismatch: expected found=%0d start=%0d end=%0d total=%0d",
                   $time, due_res.found, due_res.start, due_res.stop, due_res.total);
          $display("%0t:                      actual   found=%0d start=%0d end=%0d total=%0d",
                   $time, seen_res.found, seen_res.start, seen_res.stop, seen_res.total);
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("testbench failed");
    $finish;
  end

  initial begin
    int total_sent;
    int phase_sent;
    foreach (window_bytes[k]) window_bytes[k] = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table
    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_PATTERN: begin
          wait_drained();
          cfg_write(PATTERN_ADDR, dir_rows[i].value);
        end
        ROW_LENGTH: begin
          wait_drained();
          cfg_write(LENGTH_ADDR, dir_rows[i].value);
        end
        default: begin
          feed_byte(dir_rows[i].value[7:0], dir_rows[i].first, dir_rows[i].fixed,
                    dir_rows[i].want);
        end
      endcase
    end
    wait_drained();

    // Random texts until enough words went in
    total_sent = 0;
    while (total_sent < RANDOM_ITEMS) begin
      random_phase($urandom_range(40, 160), phase_sent);
      total_sent += phase_sent;
    end

    wait_drained();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0 && pending_matches.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
